// ===== design/stt_pkg.sv =====
// Package: sizes, codes and shared types of the software timer table.
`timescale 1ns / 1ps
package stt_pkg;

    localparam int POOL_DEPTH = 16;
    localparam int ID_BITS    = 8;
    localparam int IDX_W      = $clog2(POOL_DEPTH);
    localparam int CNT_W      = $clog2(POOL_DEPTH + 1);
    localparam int TIME_W     = 32;

    localparam logic [1:0] FUNC_SET    = 2'd0;
    localparam logic [1:0] FUNC_REMOVE = 2'd1;
    localparam logic [1:0] FUNC_TICK   = 2'd2;

    localparam logic [1:0] KIND_SET    = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_EXPIRY = 2'd2;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_FULL      = 2'd1;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic [TIME_W-1:0] new_count;
        logic              zero;
        logic              key_hit;
    } unit_res_t;

endpackage

// ===== design/stt_unit.sv =====
// Shared unit: saturating count subtract and key compare for one slot.
`timescale 1ns / 1ps
module stt_unit
    import stt_pkg::*;
(
    input  logic [TIME_W-1:0]  count,
    input  logic [TIME_W-1:0]  elapsed,
    input  logic [ID_BITS-1:0] slot_task,
    input  logic [ID_BITS-1:0] slot_signal,
    input  logic [ID_BITS-1:0] key_task,
    input  logic [ID_BITS-1:0] key_signal,
    output unit_res_t          res
);

    always_comb
    begin
        res.new_count = (elapsed < count) ? (count - elapsed) : '0;
        res.zero      = (res.new_count == '0);
        res.key_hit   = (slot_task == key_task) && (slot_signal == key_signal);
    end

endmodule

// ===== design/software_timer_table_top.sv =====
// Top level: timer table with its walking sequencer and result register.
//
//  channel   direction  ports                                               handshake
//  request   in         func dest_task signal duration periodic elapsed     start & !busy
//  result    out        kind status expired_task expired_signal last        done, one cycle
//
// Set and remove walk the order list for a match.
// A tick walks every live timer once through the shared subtract unit, one
// timer a cycle, then flushes the final expiry once the walk has ended.
// Each result is shown for one cycle on done; the receiver cannot stall.
// Reset clears the used flags, the live count and the sequencer.
`timescale 1ns / 1ps
module software_timer_table_top
    import stt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         func,
    input  logic [7:0]         dest_task,
    input  logic [7:0]         signal,
    input  logic [31:0]        duration,
    input  logic               periodic,
    input  logic [31:0]        elapsed,
    output logic               done,
    output logic [1:0]         kind,
    output logic [1:0]         status,
    output logic [7:0]         expired_task,
    output logic [7:0]         expired_signal,
    output logic               last
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_FIND = 2'd1;
    localparam logic [1:0] ST_TICK = 2'd2;

    logic [1:0]          state_reg;
    logic [1:0]          func_reg;
    logic [ID_BITS-1:0]  task_reg;
    logic [ID_BITS-1:0]  sig_reg;
    logic [TIME_W-1:0]   dur_reg;
    logic                per_reg;
    logic [TIME_W-1:0]   el_reg;
    logic [CNT_W-1:0]    pos_reg;
    logic [CNT_W-1:0]    active_reg;

    logic [POOL_DEPTH-1:0] used_reg;
    logic [ID_BITS-1:0]    slot_task_reg   [POOL_DEPTH];
    logic [ID_BITS-1:0]    slot_signal_reg [POOL_DEPTH];
    logic [TIME_W-1:0]     slot_count_reg  [POOL_DEPTH];
    logic [TIME_W-1:0]     slot_period_reg [POOL_DEPTH];
    logic [IDX_W-1:0]      order_reg       [POOL_DEPTH];

    // pending expiry, held until we know whether it is the final one
    logic                hold_valid_reg;
    logic [ID_BITS-1:0]  hold_task_reg;
    logic [ID_BITS-1:0]  hold_sig_reg;

    logic                done_reg;
    logic [1:0]          kind_reg;
    logic [1:0]          status_reg;
    logic [7:0]          xtask_reg;
    logic [7:0]          xsig_reg;
    logic                last_reg;

    logic [IDX_W-1:0]    cur_slot;
    logic                at_end;
    unit_res_t           ures;
    logic [IDX_W-1:0]    free_slot;
    logic                free_found;

    assign cur_slot = order_reg[pos_reg[IDX_W-1:0]];
    assign at_end   = (pos_reg >= active_reg);

    stt_unit u_unit (
        .count       (slot_count_reg[cur_slot]),
        .elapsed     (el_reg),
        .slot_task   (slot_task_reg[cur_slot]),
        .slot_signal (slot_signal_reg[cur_slot]),
        .key_task    (task_reg),
        .key_signal  (sig_reg),
        .res         (ures)
    );

    always_comb
    begin
        free_slot  = '0;
        free_found = 1'b0;
        for (int i = POOL_DEPTH - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_slot  = IDX_W'(i);
                free_found = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pos_reg        <= '0;
            active_reg     <= '0;
            used_reg       <= '0;
            hold_valid_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    done_reg <= 1'b0;
                    if (start)
                    begin
                        func_reg       <= func;
                        task_reg       <= dest_task;
                        sig_reg        <= signal;
                        dur_reg        <= duration;
                        per_reg        <= periodic;
                        el_reg         <= elapsed;
                        pos_reg        <= '0;
                        hold_valid_reg <= 1'b0;
                        if (func == FUNC_SET || func == FUNC_REMOVE)
                            state_reg <= ST_FIND;
                        else if (func == FUNC_TICK)
                            state_reg <= ST_TICK;
                    end
                end
                ST_FIND:
                begin
                    done_reg <= at_end || ures.key_hit;
                    if (at_end || ures.key_hit)
                    begin
                        state_reg  <= ST_IDLE;
                        last_reg   <= 1'b1;
                        xtask_reg  <= '0;
                        xsig_reg   <= '0;
                        kind_reg   <= (func_reg == FUNC_SET) ? KIND_SET : KIND_REMOVE;
                    end
                    if (!at_end && ures.key_hit)
                    begin
                        status_reg <= STAT_OK;
                        if (func_reg == FUNC_SET)
                            slot_count_reg[cur_slot] <= dur_reg;
                        else
                        begin
                            used_reg[cur_slot] <= 1'b0;
                            for (int i = 0; i < POOL_DEPTH - 1; i++)
                                if (CNT_W'(i) >= pos_reg)
                                    order_reg[i] <= order_reg[i+1];
                            active_reg <= active_reg - 1'b1;
                        end
                    end
                    else if (at_end)
                    begin
                        if (func_reg == FUNC_REMOVE)
                            status_reg <= STAT_NOT_FOUND;
                        else if (!free_found || active_reg >= CNT_W'(POOL_DEPTH))
                            status_reg <= STAT_FULL;
                        else
                        begin
                            status_reg                 <= STAT_OK;
                            used_reg[free_slot]        <= 1'b1;
                            slot_task_reg[free_slot]   <= task_reg;
                            slot_signal_reg[free_slot] <= sig_reg;
                            slot_count_reg[free_slot]  <= dur_reg;
                            slot_period_reg[free_slot] <= per_reg ? dur_reg : '0;
                            for (int i = 1; i < POOL_DEPTH; i++)
                                order_reg[i] <= order_reg[i-1];
                            order_reg[0] <= free_slot;
                            active_reg   <= active_reg + 1'b1;
                        end
                    end
                    else
                        pos_reg <= pos_reg + 1'b1;
                end
                ST_TICK:
                begin
                    if (at_end)
                    begin
                        state_reg <= ST_IDLE;
                        done_reg  <= hold_valid_reg;
                        if (hold_valid_reg)
                        begin
                            kind_reg   <= KIND_EXPIRY;
                            status_reg <= STAT_OK;
                            xtask_reg  <= hold_task_reg;
                            xsig_reg   <= hold_sig_reg;
                            last_reg   <= 1'b1;
                        end
                    end
                    else if (ures.zero)
                    begin
                        done_reg <= hold_valid_reg;
                        if (hold_valid_reg)
                        begin
                            kind_reg   <= KIND_EXPIRY;
                            status_reg <= STAT_OK;
                            xtask_reg  <= hold_task_reg;
                            xsig_reg   <= hold_sig_reg;
                            last_reg   <= 1'b0;
                        end
                        hold_valid_reg <= 1'b1;
                        hold_task_reg  <= slot_task_reg[cur_slot];
                        hold_sig_reg   <= slot_signal_reg[cur_slot];
                        if (slot_period_reg[cur_slot] != '0)
                        begin
                            slot_count_reg[cur_slot] <= slot_period_reg[cur_slot];
                            pos_reg <= pos_reg + 1'b1;
                        end
                        else
                        begin
                            // one-shot: drop it and close the gap in the order
                            used_reg[cur_slot] <= 1'b0;
                            for (int i = 0; i < POOL_DEPTH - 1; i++)
                                if (CNT_W'(i) >= pos_reg)
                                    order_reg[i] <= order_reg[i+1];
                            active_reg <= active_reg - 1'b1;
                        end
                    end
                    else
                    begin
                        done_reg <= 1'b0;
                        slot_count_reg[cur_slot] <= ures.new_count;
                        pos_reg <= pos_reg + 1'b1;
                    end
                end
                default:
                begin
                    done_reg  <= 1'b0;
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy           = (state_reg != ST_IDLE);
    assign done           = done_reg;
    assign kind           = kind_reg;
    assign status         = status_reg;
    assign expired_task   = xtask_reg;
    assign expired_signal = xsig_reg;
    assign last           = last_reg;

endmodule
